// ----- hw/rtl/kwsm_pkg.sv -----
// Shared types and constants for the k-way sorted merge block.
`timescale 1ns / 1ps
`default_nettype none

package kwsm_pkg;

  // Fixed field widths of the block's ports.
  localparam int ID_W  = 3;
  localparam int VAL_W = 32;
  localparam int CFG_W = 4;

  // Upper bounds on the list geometry, used to size the command word.
  localparam int MAX_LISTS = 8;
  localparam int LEN_W     = 4;
  localparam int POS_W     = 3;
  localparam int TOT_W     = 7;

  // Reset value of the list count register.
  localparam logic [CFG_W-1:0] LIST_COUNT_RESET = 4'd8;

  // Command queue geometry between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // One classified input transaction as handed from front to back.
  typedef struct packed {
    logic                              write;
    logic                              done;
    logic                              drop;
    logic [ID_W-1:0]                   id;
    logic [POS_W-1:0]                  pos;
    logic [VAL_W-1:0]                  value;
    logic [MAX_LISTS-1:0][LEN_W-1:0]   lens;
    logic [TOT_W-1:0]                  total;
  } cmd_t;

  // Queue status seen by the front part.
  typedef struct packed {
    logic valid;
    logic full;
  } queue_stat_t;

  // Front part status: running batch size and drop flag.
  typedef struct packed {
    logic [TOT_W-1:0] total;
    logic             dropped;
  } front_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/k_way_sorted_merge.sv -----
// Top level of the k-way sorted merge block.
//
//   Channel   Direction  Handshake             Payload
//   ------    ---------  --------------------  ------------------------------------------
//   input     in         in_valid / in_ready   list_id, elem_value, load_done
//   output    out        out_valid / out_ready merged_value, source_list, final_result,
//                                              dropped_any
//   config    in         cfg_wr_en             cfg_wr_data (list_count)
//
// Loading takes one transaction per cycle while the two-entry command queue has room.
// For each merged result the head scan visits one list per cycle through the element
// store's single registered read port, then selects and emits.
// While a merge runs the queue takes up to two transactions of the next batch, then
// in_ready stays low until the merge ends.
// Reset is synchronous; the element store is not cleared and needs no clearing pass.
// A stalled output holds in the result register; the merge waits behind it.
`timescale 1ns / 1ps
`default_nettype none

module k_way_sorted_merge #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [kwsm_pkg::CFG_W-1:0]  cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [kwsm_pkg::ID_W-1:0]   list_id,
  input  wire logic [kwsm_pkg::VAL_W-1:0]  elem_value,
  input  wire logic                        load_done,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [kwsm_pkg::VAL_W-1:0]       merged_value,
  output logic [kwsm_pkg::ID_W-1:0]        source_list,
  output logic                             final_result,
  output logic                             dropped_any
);

  logic [kwsm_pkg::CFG_W-1:0]  list_count;
  logic                        push;
  logic                        pop;
  kwsm_pkg::cmd_t              front_cmd;
  kwsm_pkg::cmd_t              back_cmd;
  kwsm_pkg::queue_stat_t       q_stat;
  kwsm_pkg::front_stat_t       fr_stat;

  // List count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      list_count <= kwsm_pkg::LIST_COUNT_RESET;
    end else if (cfg_wr_en) begin
      list_count <= cfg_wr_data;
    end
  end

  kwsm_front #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .list_count (list_count),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .list_id    (list_id),
    .elem_value (elem_value),
    .load_done  (load_done),
    .q_full     (q_stat.full),
    .push       (push),
    .cmd        (front_cmd),
    .stat       (fr_stat)
  );

  kwsm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (front_cmd),
    .pop     (pop),
    .cmd_out (back_cmd),
    .stat    (q_stat)
  );

  kwsm_back #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_stat.valid),
    .cmd          (back_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .merged_value (merged_value),
    .source_list  (source_list),
    .final_result (final_result),
    .dropped_any  (dropped_any)
  );

  // A result always names a list that exists.
  a_source_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, source_list} < (kwsm_pkg::ID_W + 1)'(NUM_LISTS)))
    else $error("result names a list that is not built");

  // The final transaction of a batch leaves the front with an empty batch.
  a_front_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && load_done) |=> (fr_stat.total == '0 && !fr_stat.dropped))
    else $error("front batch state not cleared after final transaction");

  // A stalled result stays presented with its payload unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(merged_value) &&
      $stable(source_list) && $stable(final_result) && $stable(dropped_any)))
    else $error("stalled result changed before it was taken");

endmodule

`default_nettype wire

// ----- hw/rtl/kwsm_front.sv -----
// Front part: accepts input transactions, tracks list fill, and classifies each element.
`timescale 1ns / 1ps
`default_nettype none

module kwsm_front #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [kwsm_pkg::CFG_W-1:0]  list_count,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [kwsm_pkg::ID_W-1:0]   list_id,
  input  wire logic [kwsm_pkg::VAL_W-1:0]  elem_value,
  input  wire logic                        load_done,
  input  wire logic                        q_full,
  output logic                             push,
  output kwsm_pkg::cmd_t                   cmd,
  output kwsm_pkg::front_stat_t            stat
);

  localparam int IDX_W = $clog2(NUM_LISTS);

  logic [kwsm_pkg::LEN_W-1:0]                             lens [NUM_LISTS];
  logic [kwsm_pkg::TOT_W-1:0]                             total;
  logic                                                   drop_flag;

  logic [kwsm_pkg::CFG_W-1:0]                             active;
  logic                                                   id_ok;
  logic [IDX_W-1:0]                                       lid;
  logic [kwsm_pkg::LEN_W-1:0]                             cur_len;
  logic                                                   append;
  logic [kwsm_pkg::MAX_LISTS-1:0][kwsm_pkg::LEN_W-1:0]    lens_next;
  logic [kwsm_pkg::TOT_W-1:0]                             total_next;

  // Lists at or above the active count, or beyond the built lists, take nothing.
  assign active  = (list_count > kwsm_pkg::CFG_W'(NUM_LISTS)) ?
                   kwsm_pkg::CFG_W'(NUM_LISTS) : list_count;
  assign id_ok   = ({1'b0, list_id} < active);
  assign lid     = list_id[IDX_W-1:0];
  assign cur_len = id_ok ? lens[lid] : '0;
  assign append  = id_ok && (cur_len < kwsm_pkg::LEN_W'(LIST_DEPTH));

  // Fill counts after this transaction; unbuilt lists read as empty.
  for (genvar g = 0; g < kwsm_pkg::MAX_LISTS; g++) begin : g_len
    if (g < NUM_LISTS) begin : g_used
      assign lens_next[g] = lens[g] +
                            kwsm_pkg::LEN_W'(append && (lid == IDX_W'(g)));
    end else begin : g_unused
      assign lens_next[g] = '0;
    end
  end

  assign total_next = total + kwsm_pkg::TOT_W'(append);

  // Classified command toward the back part.
  always_comb begin
    cmd.write = append;
    cmd.done  = load_done;
    cmd.drop  = drop_flag | ~append;
    cmd.id    = list_id;
    cmd.pos   = cur_len[kwsm_pkg::POS_W-1:0];
    cmd.value = elem_value;
    cmd.lens  = lens_next;
    cmd.total = total_next;
  end

  assign in_ready     = ~q_full;
  assign push         = in_valid & in_ready;
  assign stat.total   = total;
  assign stat.dropped = drop_flag;

  // Batch bookkeeping; the final transaction hands the counts over and clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        lens[i] <= '0;
      end
      total     <= '0;
      drop_flag <= 1'b0;
    end else if (push) begin
      if (load_done) begin
        for (int i = 0; i < NUM_LISTS; i++) begin
          lens[i] <= '0;
        end
        total     <= '0;
        drop_flag <= 1'b0;
      end else begin
        for (int i = 0; i < NUM_LISTS; i++) begin
          lens[i] <= lens_next[i];
        end
        total     <= total_next;
        drop_flag <= cmd.drop;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/kwsm_queue.sv -----
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module kwsm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  kwsm_pkg::cmd_t       cmd_in,
  input  wire logic            pop,
  output kwsm_pkg::cmd_t       cmd_out,
  output kwsm_pkg::queue_stat_t stat
);

  kwsm_pkg::cmd_t                entries [kwsm_pkg::QUEUE_DEPTH];
  logic [kwsm_pkg::QPTR_W-1:0]   wr_ptr;
  logic [kwsm_pkg::QPTR_W-1:0]   rd_ptr;
  logic [kwsm_pkg::QCNT_W-1:0]   count;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == kwsm_pkg::QCNT_W'(kwsm_pkg::QUEUE_DEPTH));
  assign cmd_out    = entries[rd_ptr];

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + kwsm_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + kwsm_pkg::QPTR_W'(1);
      end
      count <= count + kwsm_pkg::QCNT_W'(push) - kwsm_pkg::QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/kwsm_back.sv -----
// Back part: element store, lane-by-lane head scan, and the result register.
`timescale 1ns / 1ps
`default_nettype none

module kwsm_back #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  kwsm_pkg::cmd_t                   cmd,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [kwsm_pkg::VAL_W-1:0]       merged_value,
  output logic [kwsm_pkg::ID_W-1:0]        source_list,
  output logic                             final_result,
  output logic                             dropped_any
);

  localparam int IDX_W     = $clog2(NUM_LISTS);
  localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETTLE,
    ST_EMIT
  } state_t;

  state_t                       state;
  logic [kwsm_pkg::VAL_W-1:0]   mem [MEM_DEPTH];
  logic [kwsm_pkg::VAL_W-1:0]   rd_data;
  logic [kwsm_pkg::LEN_W-1:0]   len [NUM_LISTS];
  logic [kwsm_pkg::LEN_W-1:0]   rp  [NUM_LISTS];
  logic [kwsm_pkg::TOT_W-1:0]   remain;
  logic                         drop_r;
  logic [IDX_W-1:0]             lane;
  logic                         p_valid;
  logic [IDX_W-1:0]             p_lane;
  logic                         found;
  logic [IDX_W-1:0]             best_lane;
  logic [kwsm_pkg::VAL_W-1:0]   best_val;

  logic                         issue_ok;
  logic [MEM_AW-1:0]            issue_addr;
  logic [MEM_AW-1:0]            wr_addr;
  logic                         take_new;
  logic                         out_free;

  // Commands are taken only between merges.
  assign pop = (state == ST_IDLE) && q_valid;

  // Head read for the lane under scan; exhausted lanes point at their first slot.
  assign issue_ok   = (rp[lane] < len[lane]);
  assign issue_addr = MEM_AW'(int'(lane) * LIST_DEPTH + (issue_ok ? int'(rp[lane]) : 0));
  assign wr_addr    = MEM_AW'(int'(cmd.id[IDX_W-1:0]) * LIST_DEPTH + int'(cmd.pos));

  // Strict less-than keeps the lower list on ties, since lanes arrive in order.
  assign take_new = p_valid && (!found || ($signed(rd_data) < $signed(best_val)));
  assign out_free = !out_valid || out_ready;

  // Element store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (pop && cmd.write) begin
      mem[wr_addr] <= cmd.value;
    end
    rd_data <= mem[issue_addr];
  end

  // Merge sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      p_valid   <= 1'b0;
      found     <= 1'b0;
      lane      <= '0;
      remain    <= '0;
      drop_r    <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        len[i] <= '0;
        rp[i]  <= '0;
      end
    end else begin
      // The emit state reloads the result register itself when it is taken.
      if (out_valid && out_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end

      p_valid <= (state == ST_SCAN) && issue_ok;
      p_lane  <= lane;

      if (take_new) begin
        found     <= 1'b1;
        best_val  <= rd_data;
        best_lane <= p_lane;
      end

      unique case (state)
        ST_IDLE: begin
          if (pop && cmd.done && (cmd.total != '0)) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
              len[i] <= cmd.lens[i];
              rp[i]  <= '0;
            end
            remain <= cmd.total;
            drop_r <= cmd.drop;
            lane   <= '0;
            found  <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (lane == IDX_W'(NUM_LISTS - 1)) begin
            lane  <= '0;
            state <= ST_SETTLE;
          end else begin
            lane <= lane + IDX_W'(1);
          end
        end
        ST_SETTLE: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            merged_value <= best_val;
            source_list  <= kwsm_pkg::ID_W'(best_lane);
            final_result <= (remain == kwsm_pkg::TOT_W'(1));
            dropped_any  <= drop_r;
            for (int i = 0; i < NUM_LISTS; i++) begin
              if (best_lane == IDX_W'(i)) begin
                rp[i] <= rp[i] + kwsm_pkg::LEN_W'(1);
              end
            end
            remain <= remain - kwsm_pkg::TOT_W'(1);
            found  <= 1'b0;
            lane   <= '0;
            state  <= (remain == kwsm_pkg::TOT_W'(1)) ? ST_IDLE : ST_SCAN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
